FILE: rtl/tbfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbfe_pkg
// Shared types, constants and tap coefficients for the three-band equalizer.
// ----------------------------------------------------------------------------
package tbfe_pkg;

    localparam int TAP_COUNT_DEF = 5;
    localparam int SAMPLE_W      = 24;
    localparam int GAIN_W        = 16;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;

    // band selectors for the coefficient lookup
    localparam int BAND_LOW  = 0;
    localparam int BAND_MID  = 1;
    localparam int BAND_HIGH = 2;

    // register map, word index
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_LOW_GAIN  = 2'd1;
    localparam logic [1:0] REG_MID_GAIN  = 2'd2;
    localparam logic [1:0] REG_HIGH_GAIN = 2'd3;

    localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 16'sd4096;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] mi;
        logic signed [SAMPLE_W-1:0] hi;
    } band_sum_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] lo;
        logic signed [GAIN_W-1:0] mi;
        logic signed [GAIN_W-1:0] hi;
    } gain_set_t;

    // Q4.12 taps, floored; taps past the fifth are zero
    function automatic logic signed [GAIN_W-1:0] tap_coef(input int band, input int idx);
        logic signed [GAIN_W-1:0] c;
        c = '0;
        case (band)
            BAND_LOW: begin
                case (idx)
                    0, 4:    c = 16'sd409;
                    1, 3:    c = 16'sd614;
                    2:       c = 16'sd2048;
                    default: c = '0;
                endcase
            end
            BAND_MID: begin
                case (idx)
                    0, 4:    c = -16'sd410;
                    1, 3:    c = 16'sd1228;
                    2:       c = 16'sd2048;
                    default: c = '0;
                endcase
            end
            BAND_HIGH: begin
                case (idx)
                    0, 4:    c = -16'sd410;
                    1, 3:    c = -16'sd615;
                    2:       c = 16'sd2048;
                    default: c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tbfe_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbfe_cell
// One tap: holds a history word and adds its three band products to the
// partial sums arriving from the previous cell, registered every cycle.
// ----------------------------------------------------------------------------
module tbfe_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  shift_en,
    input  wire logic signed [tbfe_pkg::SAMPLE_W-1:0]  hist_in,
    input  wire tbfe_pkg::band_sum_t                   sum_in,
    output logic signed [tbfe_pkg::SAMPLE_W-1:0]       hist_out,
    output tbfe_pkg::band_sum_t                        sum_out
);
    import tbfe_pkg::*;

    localparam logic signed [GAIN_W-1:0] C_LO = tap_coef(BAND_LOW, INDEX);
    localparam logic signed [GAIN_W-1:0] C_MI = tap_coef(BAND_MID, INDEX);
    localparam logic signed [GAIN_W-1:0] C_HI = tap_coef(BAND_HIGH, INDEX);
    localparam int PROD_W = SAMPLE_W + GAIN_W;

    logic signed [SAMPLE_W-1:0] hist_reg;
    band_sum_t                  sum_reg;
    band_sum_t                  sum_next;
    logic signed [PROD_W-1:0]   prod_lo;
    logic signed [PROD_W-1:0]   prod_mi;
    logic signed [PROD_W-1:0]   prod_hi;

    always_comb begin
        prod_lo = hist_reg * C_LO;
        prod_mi = hist_reg * C_MI;
        prod_hi = hist_reg * C_HI;
        // floor by 4096 is the arithmetic shift; keep 24 bits, sum wraps
        sum_next.lo = sum_in.lo + prod_lo[SAMPLE_W+11:12];
        sum_next.mi = sum_in.mi + prod_mi[SAMPLE_W+11:12];
        sum_next.hi = sum_in.hi + prod_hi[SAMPLE_W+11:12];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (shift_en) begin
            hist_reg <= hist_in;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign hist_out = hist_reg;
    assign sum_out  = sum_reg;

endmodule
`default_nettype wire

FILE: rtl/tbfe_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbfe_mix
// Band gain multipliers (registered), then sum, floor and 24-bit saturate.
// ----------------------------------------------------------------------------
module tbfe_mix (
    input  wire logic                                  aclk,
    input  wire logic                                  load,
    input  wire tbfe_pkg::band_sum_t                   bands,
    input  wire tbfe_pkg::gain_set_t                   gains,
    output logic signed [tbfe_pkg::SAMPLE_W-1:0]       mix_out
);
    import tbfe_pkg::*;

    localparam int PROD_W = SAMPLE_W + GAIN_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FLR_W  = SUM_W - 12;

    logic signed [PROD_W-1:0] lo_prod_reg;
    logic signed [PROD_W-1:0] mi_prod_reg;
    logic signed [PROD_W-1:0] hi_prod_reg;
    logic signed [PROD_W-1:0] lo_prod_next;
    logic signed [PROD_W-1:0] mi_prod_next;
    logic signed [PROD_W-1:0] hi_prod_next;
    logic signed [SUM_W-1:0]  mix_sum;
    logic signed [FLR_W-1:0]  mix_flr;

    always_comb begin
        lo_prod_next = bands.lo * gains.lo;
        mi_prod_next = bands.mi * gains.mi;
        hi_prod_next = bands.hi * gains.hi;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lo_prod_reg <= lo_prod_next;
            mi_prod_reg <= mi_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
    end

    always_comb begin
        mix_sum = SUM_W'(lo_prod_reg) + SUM_W'(mi_prod_reg) + SUM_W'(hi_prod_reg);
        mix_flr = mix_sum[SUM_W-1:12];
        // in range when all bits above the 24-bit sign agree with it
        if (mix_flr[FLR_W-1:SAMPLE_W-1] == '0 || mix_flr[FLR_W-1:SAMPLE_W-1] == '1) begin
            mix_out = mix_flr[SAMPLE_W-1:0];
        end else if (mix_flr[FLR_W-1]) begin
            mix_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            mix_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/three_band_fir_equalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_band_fir_equalizer_top
// Three-band FIR graphic equalizer over a shared delay line of tap cells.
//
//   port group   dir   word contents
//   s_axis       in    tdata[23:0] sample_in, tlast last_in
//   m_axis       out   tdata[23:0] sample_out, tlast last_out
//   apb          in    eq_enable, low/mid/high band gain at 0x0/0x4/0x8/0xC
//
// Equalized word: the band sums ripple through the cell chain one cell per
// cycle (ST_MAC), the gain products are registered (ST_MIX), then the sum/
// saturate (ST_SUM) or bypassed (ST_BYPASS) word enters the output register.
// One word in flight; s_tready returns once the result reaches the output
// register, which then waits for m_tready without holding up the input.
// Reset clears the delay line and loads enable=1 and unity gains.
// ----------------------------------------------------------------------------
module three_band_fir_equalizer_top #(
    parameter int TAP_COUNT = tbfe_pkg::TAP_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // sample_in [23:0]
    input  wire logic [23:0]                    s_tdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tlast,
    output logic                                s_tready,
    // sample_out [23:0]
    output logic [23:0]                         m_tdata,
    output logic                                m_tvalid,
    output logic                                m_tlast,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tbfe_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tbfe_pkg::PDATA_W-1:0]   pwdata,
    output logic [tbfe_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import tbfe_pkg::*;

    localparam int CNT_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MAC    = 3'd1;
    localparam logic [2:0] ST_MIX    = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_BYPASS = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    eq_enable_reg;
    gain_set_t               gain_reg;
    logic [SAMPLE_W-1:0]     byp_data_reg;
    logic                    last_reg;
    logic                    m_tvalid_reg;
    logic [SAMPLE_W-1:0]     m_tdata_reg;
    logic                    m_tlast_reg;

    logic                    in_accept;
    logic                    cfg_write;
    logic                    out_free;
    logic                    out_load;
    logic [SAMPLE_W-1:0]     out_data;
    logic                    shift_en;
    logic                    mix_load;
    logic signed [SAMPLE_W-1:0] mix_out;

    logic signed [SAMPLE_W-1:0] hist_chain [TAP_COUNT];
    band_sum_t                  sum_chain  [TAP_COUNT];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign shift_en  = in_accept && eq_enable_reg;
    assign mix_load  = (state_reg == ST_MIX);
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eq_enable_reg <= 1'b1;
            gain_reg.lo   <= GAIN_UNITY;
            gain_reg.mi   <= GAIN_UNITY;
            gain_reg.hi   <= GAIN_UNITY;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_ENABLE:    eq_enable_reg <= pwdata[0];
                REG_LOW_GAIN:  gain_reg.lo   <= pwdata[GAIN_W-1:0];
                REG_MID_GAIN:  gain_reg.mi   <= pwdata[GAIN_W-1:0];
                REG_HIGH_GAIN: gain_reg.hi   <= pwdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENABLE:    prdata = {{(PDATA_W-1){1'b0}}, eq_enable_reg};
            REG_LOW_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, gain_reg.lo};
            REG_MID_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, gain_reg.mi};
            REG_HIGH_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, gain_reg.hi};
            default:       prdata = '0;
        endcase
    end

    // ---------------- tap cell chain ----------------
    for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
        if (i == 0) begin : g_head
            tbfe_cell #(.INDEX(i)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .hist_in  (s_tdata),
                .sum_in   ('0),
                .hist_out (hist_chain[i]),
                .sum_out  (sum_chain[i])
            );
        end else begin : g_body
            tbfe_cell #(.INDEX(i)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .hist_in  (hist_chain[i-1]),
                .sum_in   (sum_chain[i-1]),
                .hist_out (hist_chain[i]),
                .sum_out  (sum_chain[i])
            );
        end
    end

    tbfe_mix u_mix (
        .aclk    (aclk),
        .load    (mix_load),
        .bands   (sum_chain[TAP_COUNT-1]),
        .gains   (gain_reg),
        .mix_out (mix_out)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        out_data   = mix_out;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_accept) begin
                    state_next = eq_enable_reg ? ST_MAC : ST_BYPASS;
                end
            end
            ST_MAC: begin
                // sums settle after one pass through every cell
                if (cnt_reg == CNT_W'(TAP_COUNT - 1)) begin
                    state_next = ST_MIX;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MIX: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BYPASS: begin
                out_data = byp_data_reg;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            byp_data_reg <= s_tdata;
            last_reg     <= s_tlast;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- assertions ----------------
    a_word_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_SUM || state_reg == ST_BYPASS))
        else $error("output word appeared without a finished computation");

    a_enabled_goes_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && eq_enable_reg) |=> (state_reg == ST_MAC && cnt_reg == '0))
        else $error("equalized word did not start accumulation");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (cnt_reg <= CNT_W'(TAP_COUNT - 1)))
        else $error("tap counter ran past the chain");

    a_hist_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |=> $stable(hist_chain[TAP_COUNT-1]))
        else $error("delay line moved during accumulation");

endmodule
`default_nettype wire

FILE: sim/tbfe_eq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbfe_eq_checker
// Watches the sample streams and the register bus of the three-band
// equalizer. It keeps its own delay line and gain copies, works out the
// output word for each accepted input word and compares it against the
// oldest outstanding word when a result is accepted.
// ----------------------------------------------------------------------------
module tbfe_eq_checker #(
    parameter int TAPS = tbfe_pkg::TAP_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [tbfe_pkg::SAMPLE_W-1:0]  s_tdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tlast,
    input  wire logic                           s_tready,
    input  wire logic [tbfe_pkg::SAMPLE_W-1:0]  m_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tlast,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tbfe_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tbfe_pkg::PDATA_W-1:0]   pwdata,
    input  wire logic                           pready,
    output int                                  fail_count,
    output int                                  pending_words,
    output int                                  checked_words,
    output int                                  bypass_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import tbfe_pkg::*;

    localparam int NUM_COEF = 5;
    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;

    // Q4.12 taps, floored; rows follow BAND_LOW, BAND_MID, BAND_HIGH
    localparam int BAND_TAPS [3][NUM_COEF] = '{
        '{ 409,   614, 2048,  614,  409},
        '{-410,  1228, 2048, 1228, -410},
        '{-410,  -615, 2048, -615, -410}
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } eq_word_t;

    logic signed [SAMPLE_W-1:0] tap_hist [TAPS];
    logic                       eq_on;
    logic signed [GAIN_W-1:0]   gain_lo, gain_mi, gain_hi;
    eq_word_t                   due_words [$];

    // FIR over the delay line; each product floored, sum wraps at 24 bits
    function automatic logic signed [SAMPLE_W-1:0] band_value(input int band);
        logic [SAMPLE_W-1:0] acc;
        longint              prod;
        acc = '0;
        for (int i = 0; i < TAPS; i++) begin
            prod = longint'(tap_hist[i]) * ((i < NUM_COEF) ? BAND_TAPS[band][i] : 0);
            prod = prod >>> 12;
            acc  = acc + prod[SAMPLE_W-1:0];
        end
        return signed'(acc);
    endfunction

    function automatic eq_word_t equalize(input logic signed [SAMPLE_W-1:0] x,
                                          input logic lst);
        eq_word_t w;
        longint   mix;
        w.last = lst;
        if (!eq_on) begin
            w.sample = x;
            return w;
        end
        for (int i = TAPS - 1; i > 0; i--)
            tap_hist[i] = tap_hist[i-1];
        tap_hist[0] = x;
        mix = longint'(band_value(BAND_LOW))  * longint'(gain_lo)
            + longint'(band_value(BAND_MID))  * longint'(gain_mi)
            + longint'(band_value(BAND_HIGH)) * longint'(gain_hi);
        mix = mix >>> 12;
        if (mix > OUT_MAX) mix = OUT_MAX;
        if (mix < OUT_MIN) mix = OUT_MIN;
        w.sample = mix[SAMPLE_W-1:0];
        return w;
    endfunction

    task automatic note_fail(input string what, input eq_word_t want, input eq_word_t got);
        if (fail_count < 10)
            $display("%0t: %s: expected sample %0d last %0b, got sample %0d last %0b",
                     $time, what, want.sample, want.last, got.sample, got.last);
        fail_count = fail_count + 1;
    endtask

    always @(posedge aclk) begin : watch
        eq_word_t got;
        eq_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++)
                tap_hist[i] = '0;
            eq_on         = 1'b1;
            gain_lo       = GAIN_UNITY;
            gain_mi       = GAIN_UNITY;
            gain_hi       = GAIN_UNITY;
            fail_count    = 0;
            checked_words = 0;
            bypass_words  = 0;
            due_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ENABLE:    eq_on   = pwdata[0];
                    REG_LOW_GAIN:  gain_lo = pwdata[GAIN_W-1:0];
                    REG_MID_GAIN:  gain_mi = pwdata[GAIN_W-1:0];
                    REG_HIGH_GAIN: gain_hi = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (!eq_on)
                    bypass_words = bypass_words + 1;
                due_words.push_back(equalize(signed'(s_tdata), s_tlast));
            end
            if (m_tvalid && m_tready) begin
                got.sample = m_tdata;
                got.last   = m_tlast;
                if (due_words.size() == 0) begin
                    want = '0;
                    note_fail("word with nothing outstanding", want, got);
                end else begin
                    want = due_words.pop_front();
                    if (got.sample !== want.sample || got.last !== want.last)
                        note_fail("output word mismatch", want, got);
                    checked_words = checked_words + 1;
                end
            end
        end
        pending_words <= due_words.size();
    end

endmodule
`default_nettype wire

FILE: sim/three_band_fir_equalizer_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_band_fir_equalizer_top_tb
// Drives samples and register writes into the three-band equalizer: a
// directed pass over extreme samples, gains and bypass, then random
// phases under random gain settings with random stalls on both streams
// and one long output hold-off. Checking is done in tbfe_eq_checker.
// ----------------------------------------------------------------------------
module three_band_fir_equalizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tbfe_pkg::*;

    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_WORDS  = 56;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     SETTLE       = TAP_COUNT_DEF + 8;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;
    localparam logic [GAIN_W-1:0] G_MAX = 16'h7FFF;
    localparam logic [GAIN_W-1:0] G_MIN = 16'h8000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [SAMPLE_W-1:0]  s_tdata  = '0;    // sample_in [23:0]
    logic                 s_tvalid = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  m_tdata;          // sample_out [23:0]
    logic                 m_tvalid;
    logic                 m_tlast;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int  fail_count, pending_words, checked_words, bypass_words;
    int  words_sent   = 0;
    int  settings_run = 0;
    bit  idle_on      = 1'b1;
    bit  hold_req     = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    three_band_fir_equalizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tbfe_eq_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tlast       (s_tlast),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tlast       (m_tlast),
        .m_tready      (m_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .checked_words (checked_words),
        .bypass_words  (bypass_words)
    );

    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // junk lands above the register width and must be dropped
    task automatic set_eq(input logic en, input logic [GAIN_W-1:0] g_lo,
                          input logic [GAIN_W-1:0] g_mid, input logic [GAIN_W-1:0] g_hi,
                          input bit junk);
        logic [PDATA_W-1:0] hi_bits;
        hi_bits = junk ? $urandom : '0;
        apb_write(REG_ENABLE,    {hi_bits[PDATA_W-1:1], en});
        apb_write(REG_LOW_GAIN,  {hi_bits[PDATA_W-1:GAIN_W], g_lo});
        apb_write(REG_MID_GAIN,  {hi_bits[PDATA_W-1:GAIN_W], g_mid});
        apb_write(REG_HIGH_GAIN, {hi_bits[PDATA_W-1:GAIN_W], g_hi});
        settings_run++;
    endtask

    task automatic send_word(input logic [SAMPLE_W-1:0] x, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tdata  <= x;
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // wait until every outstanding word is out and the pipe is quiet
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain;
        case ($urandom_range(0, 5))
            0:       return G_MAX;
            1:       return G_MIN;
            2:       return '0;
            3:       return GAIN_UNITY;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample;
        logic signed [SAMPLE_W-1:0] small_val;
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3: begin
                small_val = SAMPLE_W'($urandom_range(0, 4095));
                return small_val - 24'sd2048;
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // output side: random stalls, plus the long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: unity gains; extremes, then band wrap patterns
        send_word('0, 1'b0);
        send_word(24'hFFFFFF, 1'b1);
        send_word(24'h000001, 1'b0);
        send_word(S_MIN, 1'b1);
        send_word(S_MAX, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word(S_MAX, 1'b1);
        send_word(S_MIN, 1'b0);   // mid band wraps here
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b1);
        send_word(S_MIN, 1'b0);
        send_word(S_MIN, 1'b1);   // high band at full swing
        drain();

        // largest gains drive the mix into saturation both ways
        set_eq(1'b1, G_MAX, G_MAX, G_MAX, 1'b0);
        repeat (3) send_word(S_MAX, 1'b0);
        repeat (3) send_word(S_MIN, 1'b1);
        drain();
        set_eq(1'b1, G_MIN, G_MIN, G_MIN, 1'b0);
        repeat (2) send_word(S_MAX, 1'b1);
        repeat (2) send_word(S_MIN, 1'b0);
        drain();

        // bypass leaves the delay line alone
        set_eq(1'b0, 16'h1234, G_MIN, G_MAX, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b1);
        send_word(24'h555555, 1'b0);
        send_word(24'hAAAAAA, 1'b1);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph != RAND_PHASES - 1);
            set_eq((ph == RAND_PHASES - 1) || ($urandom_range(0, 4) != 0),
                   pick_gain(), pick_gain(), pick_gain(), 1'b1);
            if (ph == 3)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(pick_sample(), $urandom_range(0, 7) == 0);
            drain();
        end

        $display("Sent %0d samples over %0d register settings (%0d bypassed), %0d results checked",
                 words_sent, settings_run, bypass_words, checked_words);
        $display("Covered extreme samples and gains, band wrap, mix saturation, bypass and stalls");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
